// File: rtl/core/qsort_pkg.sv
// qsort_pkg: shared types for the quicksort engine
// request structs, controller state enum, controller/datapath command and status
`timescale 1ns / 1ps
package qsort_pkg;

	typedef struct packed {
		logic signed [15:0] value;
		logic               last_in;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] sorted_value;
		logic               last_out;
		logic [10:0]        comparisons;
	} out_req_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_POP,
		ST_PIVOT,
		ST_RDJ,
		ST_CMP,
		ST_WRJ,
		ST_FINRD,
		ST_FINWR,
		ST_PUSH,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic start;
		logic pop;
		logic rd_pivot;
		logic rd_j;
		logic cmp;
		logic wr_j;
		logic fin_rd;
		logic fin_wr;
		logic push;
		logic emit_rd;
		logic emit_adv;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic stack_empty;
		logic range_ok;
		logic j_end;
		logic le;
		logic emit_last;
		logic push_more;
	} sts_t;

endpackage

// File: rtl/core/qsort_ctrl.sv
// qsort_ctrl: sequencer for load, partition passes and emit
// depends on qsort_pkg
`timescale 1ns / 1ps
module qsort_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic              out_free,
	input  qsort_pkg::sts_t   sts,
	output logic              in_stall,
	output logic              out_load,
	output qsort_pkg::cmd_t   cmd
);
	import qsort_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (in_valid && in_last) state_d = ST_START;
			ST_START:   state_d = ST_POP;
			ST_POP:     state_d = sts.stack_empty ? ST_EMIT_RD : ST_PIVOT;
			ST_PIVOT:   state_d = sts.range_ok ? ST_RDJ : ST_POP;
			ST_RDJ:     state_d = sts.j_end ? ST_FINRD : ST_CMP;
			ST_CMP:     state_d = sts.le ? ST_WRJ : ST_RDJ;
			ST_WRJ:     state_d = ST_RDJ;
			ST_FINRD:   state_d = ST_FINWR;
			ST_FINWR:   state_d = ST_PUSH;
			ST_PUSH:    state_d = sts.push_more ? ST_PUSH : ST_POP;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT:    if (out_free) state_d = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall    = 1'b0;
				cmd.load_wr = in_valid && !sts.full;
			end
			ST_START:   cmd.start    = 1'b1;
			ST_POP:     cmd.pop      = 1'b1;
			ST_PIVOT:   cmd.rd_pivot = 1'b1;
			ST_RDJ:     cmd.rd_j     = 1'b1;
			ST_CMP:     cmd.cmp      = 1'b1;
			ST_WRJ:     cmd.wr_j     = 1'b1;
			ST_FINRD:   cmd.fin_rd   = 1'b1;
			ST_FINWR:   cmd.fin_wr   = 1'b1;
			ST_PUSH:    cmd.push     = 1'b1;
			ST_EMIT_RD: cmd.emit_rd  = 1'b1;
			ST_EMIT: begin
				out_load     = out_free;
				cmd.emit_adv = out_free;
				cmd.done     = out_free && sts.emit_last;
			end
			default: ;
		endcase
	end
endmodule

// File: rtl/core/qsort_dp.sv
// qsort_dp: element memory, range stack, indexes and compare counter
// depends on qsort_pkg
`timescale 1ns / 1ps
module qsort_dp #(
	parameter int N  = 64,
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qsort_pkg::cmd_t    cmd,
	input  logic signed [15:0] in_value,
	output qsort_pkg::sts_t    sts,
	output logic signed [15:0] emit_value,
	output logic [10:0]        emit_count
);
	import qsort_pkg::*;

	logic signed [15:0] mem [N];
	logic [2*IW-1:0]    stk [N];
	logic signed [15:0] rd_q, pivot_q;
	logic [2*IW-1:0]    top_q;
	logic [CW-1:0]      cnt_q, sp_q;
	logic [IW-1:0]      lo_q, hi_q, i_q, j_q, k_q;
	logic [10:0]        cmp_q;
	logic [1:0]         pend_q;

	logic [IW-1:0] p_lo, p_hi;
	logic push_right, push_left;
	assign p_lo       = top_q[IW-1:0];
	assign p_hi       = top_q[2*IW-1:IW];
	assign push_right = ({1'b0, i_q} + 1'b1) < {1'b0, hi_q};
	assign push_left  = {1'b0, i_q} > ({1'b0, lo_q} + 1'b1);

	// memory port: one read, one write per cycle
	logic          we;
	logic [IW-1:0] wa, ra;
	logic signed [15:0] wd;
	always_comb begin
		we = 1'b0; wa = j_q; wd = rd_q; ra = k_q;
		if (cmd.load_wr) begin
			we = 1'b1; wa = cnt_q[IW-1:0]; wd = in_value;
		end else if (cmd.cmp && rd_q <= pivot_q) begin
			we = 1'b1; wa = i_q; wd = rd_q;     // element j moves to slot i
		end else if (cmd.wr_j) begin
			we = 1'b1; wa = j_q - 1'b1; wd = rd_q;   // old element i lands in slot j
		end else if (cmd.fin_wr) begin
			we = 1'b1; wa = i_q; wd = pivot_q;
		end else if (cmd.fin_rd) begin
			we = 1'b1; wa = hi_q; wd = rd_q;     // element i read at end of scan
		end
		if (cmd.rd_pivot)      ra = p_hi;
		else if (cmd.rd_j)     ra = sts.j_end ? i_q : j_q;
		else if (cmd.cmp)      ra = i_q;
		else if (cmd.emit_rd)  ra = k_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
		top_q <= stk[sp_q[IW-1:0] - 1'b1];
		if (cmd.push || cmd.start) begin
			if (cmd.start)
				stk[0] <= {IW'(cnt_q - 1'b1), {IW{1'b0}}};
			else if (pend_q[0] && push_right)
				stk[sp_q[IW-1:0]] <= {hi_q, i_q + 1'b1};
			else
				stk[sp_q[IW-1:0]] <= {i_q - 1'b1, lo_q};
		end
		if (cmd.rd_pivot) begin lo_q <= p_lo; hi_q <= p_hi; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; sp_q <= '0; cmp_q <= '0; i_q <= '0; j_q <= '0;
			k_q <= '0; pend_q <= '0;
		end else begin
			if (cmd.load_wr) cnt_q <= cnt_q + 1'b1;
			if (cmd.start) begin
				cmp_q <= '0; k_q <= '0;
				sp_q  <= (cnt_q > CW'(1)) ? CW'(1) : '0;
			end
			if (cmd.pop) sp_q <= sp_q - 1'b1;
			if (cmd.rd_pivot) begin i_q <= p_lo; j_q <= p_lo; end
			if (cmd.rd_j && !sts.j_end) j_q <= j_q + 1'b1;
			if (cmd.rd_j && sts.j_end)  j_q <= i_q;
			if (cmd.cmp) begin
				if (cmp_q != 11'h7ff) cmp_q <= cmp_q + 1'b1;
				if (rd_q <= pivot_q) i_q <= i_q + 1'b1;
			end
			if (cmd.fin_rd) pend_q <= 2'b11;
			if (cmd.push) begin
				if (pend_q[0]) begin
					pend_q[0] <= 1'b0;
					if (push_right) sp_q <= sp_q + 1'b1;
				end else begin
					pend_q[1] <= 1'b0;
					if (push_left) sp_q <= sp_q + 1'b1;
				end
			end
			if (cmd.emit_adv) k_q <= k_q + 1'b1;
			if (cmd.done) begin cnt_q <= '0; sp_q <= '0; end
		end
	end

	// pivot latch: the memory read launched in PIVOT arrives next cycle (first RDJ)
	logic piv_ld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) piv_ld_q <= 1'b0;
		else         piv_ld_q <= cmd.rd_pivot && (p_lo < p_hi);
	end
	always_ff @(posedge clk) if (piv_ld_q) pivot_q <= rd_q;

	always_comb begin
		sts.full        = cnt_q >= CW'(N);
		sts.stack_empty = sp_q == '0;
		sts.range_ok    = p_lo < p_hi;
		sts.j_end       = j_q == hi_q;
		sts.le          = rd_q <= pivot_q;
		sts.emit_last   = {1'b0, k_q} == (cnt_q - 1'b1);
		sts.push_more   = pend_q[0];
	end
	assign emit_value = rd_q;
	assign emit_count = cmp_q;
endmodule

// File: rtl/core/quicksort_engine_with_compare_count.sv
// quicksort engine: loads up to MAX_ELEMENTS values, sorts with lomuto quicksort, emits
// load accepts a request whenever one is offered; each comparison takes RDJ and CMP (and
// WRJ when it moves an element), bound by the element memory's single read port; each
// result is read in EMIT_RD and offered in EMIT; one set in flight at a time
// reset (arst_n low) clears the count and stack and returns to loading
// depends on qsort_pkg, qsort_ctrl, qsort_dp
`timescale 1ns / 1ps
module quicksort_engine_with_compare_count #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qsort_pkg::in_req_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output qsort_pkg::out_req_t out_data
);
	import qsort_pkg::*;

	localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	cmd_t cmd;
	sts_t sts;
	logic out_load, out_free;
	logic signed [15:0] emit_value;
	logic [10:0] emit_count;

	assign out_free = !out_valid || !out_stall;

	qsort_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_last(in_data.last_in), .out_free, .sts,
		.in_stall, .out_load, .cmd
	);

	qsort_dp #(.N(MAX_ELEMENTS), .IW(IW), .CW(CW)) u_dp (
		.clk, .arst_n, .cmd, .in_value(in_data.value), .sts, .emit_value, .emit_count
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_valid <= 1'b0;
		else if (out_load)      out_valid <= 1'b1;
		else if (!out_stall)    out_valid <= 1'b0;
	end
	always_ff @(posedge clk)
		if (out_load) out_data <= '{emit_value, sts.emit_last, emit_count};

`ifndef SYNTH
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_load) else $error("input taken during emit");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd) || (cmd.done && cmd.emit_adv && $countones(cmd) == 2))
		else $error("more than one datapath command");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
`endif
endmodule

// File: test/quicksort_engine_with_compare_count_tb.sv
// testbench for quicksort_engine_with_compare_count: loads sets of signed values,
// predicts the sorted order and comparison count, checks every emitted request
// depends on qsort_pkg and the engine rtl
`timescale 1ns / 1ps
module quicksort_engine_with_compare_count_tb;
	import qsort_pkg::*;

	localparam int MAX_ELEMENTS = 64;
	localparam int WATCHDOG_LIMIT = 40000;

	class sort_scoreboard;
		logic signed [15:0] pending_set[$];
		out_req_t sorted_queue[$];
		int errors;

		// lomuto quicksort with explicit range stack, counting every comparison
		function void sort_and_queue();
			logic signed [15:0] store[MAX_ELEMENTS];
			logic signed [15:0] pivot, tmp;
			int lo_stack[$], hi_stack[$];
			int lo, hi, i, j, n;
			logic [10:0] cmp_count;
			n = pending_set.size();
			cmp_count = 0;
			for (int k = 0; k < n; k++) store[k] = pending_set[k];
			if (n >= 2) begin
				lo_stack.push_back(0);
				hi_stack.push_back(n - 1);
			end
			while (lo_stack.size() > 0) begin
				lo = lo_stack.pop_back();
				hi = hi_stack.pop_back();
				if (lo >= hi) continue;
				pivot = store[hi];
				i = lo;
				for (j = lo; j < hi; j++) begin
					cmp_count++;
					if (store[j] <= pivot) begin
						tmp = store[i]; store[i] = store[j]; store[j] = tmp;
						i++;
					end
				end
				tmp = store[i]; store[i] = store[hi]; store[hi] = tmp;
				if (i + 1 < hi) begin
					lo_stack.push_back(i + 1);
					hi_stack.push_back(hi);
				end
				if (i > lo + 1) begin
					lo_stack.push_back(lo);
					hi_stack.push_back(i - 1);
				end
			end
			for (int k = 0; k < n; k++)
				sorted_queue.push_back('{sorted_value: store[k], last_out: (k == n - 1),
					comparisons: cmp_count});
			pending_set.delete();
		endfunction

		function void note_request(in_req_t req);
			if (pending_set.size() < MAX_ELEMENTS) pending_set.push_back(req.value);
			if (req.last_in) sort_and_queue();
		endfunction

		function void check_result(out_req_t got);
			out_req_t exp;
			if (sorted_queue.size() == 0) begin
				$error("unexpected result value=%0d", got.sorted_value);
				errors++;
				return;
			end
			exp = sorted_queue.pop_front();
			if (got.sorted_value !== exp.sorted_value) begin
				$error("sorted_value expected %0d got %0d", exp.sorted_value, got.sorted_value);
				errors++;
			end
			if (got.last_out !== exp.last_out) begin
				$error("last_out expected %0d got %0d", exp.last_out, got.last_out);
				errors++;
			end
			if (got.comparisons !== exp.comparisons) begin
				$error("comparisons expected %0d got %0d", exp.comparisons, got.comparisons);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_req_t out_data;

	sort_scoreboard board = new();
	int send_idle_pct, recv_idle_pct;
	bit hold_off = 0;
	int idle_cycles = 0;

	quicksort_engine_with_compare_count #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	// receiver stall and result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// offer one request, with optional idle gaps, and wait for acceptance
	task automatic send_request(logic signed [15:0] v, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{value: v, last_in: last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request('{value: v, last_in: last});
	endtask

	task automatic send_set(int n, int mode);
		logic signed [15:0] v;
		for (int k = 0; k < n; k++) begin
			case (mode)
				0: v = 16'($urandom);
				1: v = 16'(int'($urandom_range(7)) - 4);
				2: v = 16'(k);
				default: v = 16'(n - k);
			endcase
			send_request(v, k == n - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.sorted_queue.size() > 0) @(posedge clk);
	endtask

	initial begin
		send_idle_pct = 7;
		recv_idle_pct = 49;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, single element, duplicates, sorted and reversed
		send_request(16'sh7fff, 1);
		send_request(-16'sd32768, 0);
		send_request(16'sh7fff, 0);
		send_request(16'sd0, 0);
		send_request(-16'sd1, 0);
		send_request(16'sh5555, 0);
		send_request(-16'sh5556, 1);
		send_set(4, 1);
		send_set(5, 2);
		send_set(5, 3);
		drain();

		// store full: 66 values sent, 64 loaded, overflow dropped; completes on last_in
		send_set(66, 0);
		drain();

		// long receiver hold-off while sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_set(3, 0);
				send_set(6, 0);
			end
		join
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
			recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 7 : 0;
			for (int s = 0; s < 4; s++)
				send_set($urandom_range(12, 1), $urandom_range(3));
			drain();
		end

		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.sorted_queue.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// File: files.f
rtl/core/qsort_pkg.sv
rtl/core/qsort_ctrl.sv
rtl/core/qsort_dp.sv
rtl/core/quicksort_engine_with_compare_count.sv
test/quicksort_engine_with_compare_count_tb.sv
